### hdl/lcu_pkg.sv
`timescale 1ns / 1ps
package lcu_pkg;

	localparam int DATA_WIDTH        = 16;
	localparam int FRAC_BITS         = 12;
	localparam int ACT_TABLE_ENTRIES = 256;

	localparam int SPAN        = DATA_WIDTH - FRAC_BITS;
	localparam int MAG_W       = DATA_WIDTH + 1;
	localparam int TAB_IDX_W   = $clog2(ACT_TABLE_ENTRIES + 1);
	localparam int PROD_W      = MAG_W + TAB_IDX_W;
	localparam int IDX_W       = PROD_W - DATA_WIDTH;
	localparam int ENT_W       = FRAC_BITS + 1;
	localparam int GATE_W      = FRAC_BITS + 2;
	localparam int HID_W       = FRAC_BITS + 2;
	localparam int IN_FIELDS   = 5;
	localparam int IN_TDATA_W  = ((IN_FIELDS * DATA_WIDTH + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((DATA_WIDTH + HID_W + 7) / 8) * 8;
	localparam int PIPE_DEPTH  = 10;
	localparam int ACT_STAGES  = 3;

	typedef struct packed {
		logic                  tanh_mode;
		logic [ACT_STAGES-1:0] en;
	} act_ctrl_t;

	function automatic logic [63:0] div_small(input logic [63:0] x, input int j);
		logic [63:0] r;
		case (j)
			1:       r = x;
			2:       r = x / 2;
			3:       r = x / 3;
			4:       r = x / 4;
			5:       r = x / 5;
			6:       r = x / 6;
			7:       r = x / 7;
			8:       r = x / 8;
			9:       r = x / 9;
			10:      r = x / 10;
			11:      r = x / 11;
			12:      r = x / 12;
			default: r = x;
		endcase
		return r;
	endfunction

	// sigmoid table entry k in Q(FRAC_BITS), built at elaboration
	function automatic logic [ENT_W-1:0] act_entry(input int k);
		logic [63:0]        a;
		logic [63:0]        term;
		logic signed [63:0] sum;
		logic [63:0]        e;
		logic [63:0]        den;
		logic [63:0]        num;
		logic [63:0]        quo;
		a    = (64'(k) << 29) / ACT_TABLE_ENTRIES;
		sum  = 64'sd1 <<< 30;
		term = 64'd1 << 30;
		for (int j = 1; j <= 12; j++) begin
			term = div_small((term * a) >> 30, j);
			if (j % 2 == 1) sum = sum - $signed(term);
			else            sum = sum + $signed(term);
		end
		e = (sum > 0) ? 64'(sum) : 64'd0;
		for (int j = 0; j <= SPAN; j++) begin
			e = (e * e + (64'd1 << 29)) >> 30;
		end
		den = (64'd1 << 30) + e;
		num = (64'd1 << (FRAC_BITS + 30)) + (den >> 1);
		quo = 64'd0;
		for (int b = FRAC_BITS + 1; b >= 0; b--) begin
			if (num >= (den << b)) begin
				num    = num - (den << b);
				quo[b] = 1'b1;
			end
		end
		return quo[ENT_W-1:0];
	endfunction

endpackage

### hdl/lcu_act.sv
`timescale 1ns / 1ps
module lcu_act (
	input  logic                                     clk,
	input  lcu_pkg::act_ctrl_t                       ctrl,
	input  logic signed [lcu_pkg::DATA_WIDTH-1:0]    x,
	output logic signed [lcu_pkg::GATE_W-1:0]        y
);

	localparam int DW    = lcu_pkg::DATA_WIDTH;
	localparam int MUL_W = lcu_pkg::ENT_W + 1 + DW + 1;
	localparam int LK_W  = lcu_pkg::GATE_W + 1;
	localparam logic signed [LK_W-1:0] ONE_Q = LK_W'(1 << lcu_pkg::FRAC_BITS);

	logic [lcu_pkg::ENT_W-1:0] act_tab [0:lcu_pkg::ACT_TABLE_ENTRIES];

	for (genvar k = 0; k <= lcu_pkg::ACT_TABLE_ENTRIES; k++) begin : g_tab
		assign act_tab[k] = lcu_pkg::act_entry(k);
	end

	logic signed [lcu_pkg::MAG_W-1:0]   xs;
	logic [lcu_pkg::MAG_W-1:0]          absx;
	logic [lcu_pkg::MAG_W-1:0]          u;
	logic [lcu_pkg::PROD_W-1:0]         p;
	logic [lcu_pkg::IDX_W-1:0]          idx;
	logic                               clamp;
	logic [lcu_pkg::TAB_IDX_W-1:0]      sel0;
	logic [lcu_pkg::TAB_IDX_W-1:0]      sel1;
	logic [lcu_pkg::ENT_W-1:0]          e0;
	logic [lcu_pkg::ENT_W-1:0]          e1;

	logic [lcu_pkg::ENT_W-1:0]          e0_s1;
	logic signed [lcu_pkg::ENT_W:0]     diff_s1;
	logic [DW-1:0]                      frac_s1;
	logic                               neg_s1;

	logic signed [MUL_W-1:0]            prod_s2;
	logic [lcu_pkg::ENT_W-1:0]          e0_s2;
	logic                               neg_s2;

	logic signed [MUL_W-1:0]            shifted;
	logic signed [LK_W-1:0]             lk;
	logic signed [LK_W-1:0]             t;
	logic signed [LK_W-1:0]             res;

	always_comb begin
		xs    = lcu_pkg::MAG_W'(x);
		absx  = x[DW-1] ? lcu_pkg::MAG_W'(-xs) : lcu_pkg::MAG_W'(xs);
		u     = ctrl.tanh_mode ? {absx[lcu_pkg::MAG_W-2:0], 1'b0} : absx;
		p     = lcu_pkg::PROD_W'(u) * lcu_pkg::PROD_W'(lcu_pkg::ACT_TABLE_ENTRIES);
		idx   = p[lcu_pkg::PROD_W-1:DW];
		clamp = idx >= lcu_pkg::IDX_W'(lcu_pkg::ACT_TABLE_ENTRIES);
		sel0  = clamp ? lcu_pkg::TAB_IDX_W'(lcu_pkg::ACT_TABLE_ENTRIES)
		              : idx[lcu_pkg::TAB_IDX_W-1:0];
		sel1  = clamp ? lcu_pkg::TAB_IDX_W'(lcu_pkg::ACT_TABLE_ENTRIES)
		              : idx[lcu_pkg::TAB_IDX_W-1:0] + lcu_pkg::TAB_IDX_W'(1);
		e0    = act_tab[sel0];
		e1    = act_tab[sel1];
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[0]) begin
			e0_s1   <= e0;
			diff_s1 <= $signed({1'b0, e1}) - $signed({1'b0, e0});
			frac_s1 <= p[DW-1:0];
			neg_s1  <= x[DW-1];
		end
		if (ctrl.en[1]) begin
			prod_s2 <= MUL_W'(diff_s1) * MUL_W'($signed({1'b0, frac_s1}));
			e0_s2   <= e0_s1;
			neg_s2  <= neg_s1;
		end
		if (ctrl.en[2]) begin
			y <= lcu_pkg::GATE_W'(res);
		end
	end

	always_comb begin
		shifted = prod_s2 >>> DW;
		lk      = $signed(LK_W'({1'b0, e0_s2})) + LK_W'(shifted);
		t       = (lk <<< 1) - ONE_Q;
		if (ctrl.tanh_mode) res = neg_s2 ? -t : t;
		else                res = neg_s2 ? ONE_Q - lk : lk;
	end

endmodule

### hdl/lstm_cell_update_top.sv
`timescale 1ns / 1ps
// LSTM cell element update: takes one element per clock while s_axis_tready is high
// and returns one result per element, in order, through the ten-stage pipeline: three
// stages of table lookup and interpolation for the gates, two for the cell products and
// saturation, three for tanh of the new cell value and two for the hidden product and
// rounding. A stalled output holds its result while earlier stages keep filling
// empty slots, so input stops only when every stage is full. s_axis_tdata carries the
// five Q3.12 operands, s_axis_tuser the continue flag; m_axis_tdata carries the
// saturated cell value and the hidden output.
module lstm_cell_update_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// in_gate_pre, forget_gate_pre, out_gate_pre, cand_pre, cell_prev
	input  logic [lcu_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// seq_continue
	input  logic                               s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// cell_next, hidden_out, zero pad
	output logic [lcu_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

	localparam int DW    = lcu_pkg::DATA_WIDTH;
	localparam int GW    = lcu_pkg::GATE_W;
	localparam int FB    = lcu_pkg::FRAC_BITS;
	localparam int ND    = lcu_pkg::PIPE_DEPTH;
	localparam int PFC_W = GW + DW;
	localparam int PIG_W = GW + GW;
	localparam int SUM_W = PFC_W + 1;
	localparam int HP_W  = GW + GW;
	localparam logic signed [SUM_W-1:0] HALF_S = SUM_W'(1 << (FB - 1));
	localparam logic signed [SUM_W-1:0] C_MAX  = SUM_W'(2 ** (DW - 1) - 1);
	localparam logic signed [SUM_W-1:0] C_MIN  = SUM_W'(-(2 ** (DW - 1)));
	localparam logic signed [HP_W-1:0]  HALF_H = HP_W'(1 << (FB - 1));
	localparam int PAD_W = lcu_pkg::OUT_TDATA_W - DW - lcu_pkg::HID_W;

	logic [ND:1]   vld_q;
	logic [ND:1]   vld_d;
	logic [ND+1:1] en;

	logic signed [DW-1:0] in_gate_pre;
	logic signed [DW-1:0] forget_gate_pre;
	logic signed [DW-1:0] out_gate_pre;
	logic signed [DW-1:0] cand_pre;
	logic signed [DW-1:0] cell_prev;

	logic signed [GW-1:0] gi;
	logic signed [GW-1:0] gf;
	logic signed [GW-1:0] go;
	logic signed [GW-1:0] gg;
	logic signed [GW-1:0] tc;

	lcu_pkg::act_ctrl_t sig_ctrl;
	lcu_pkg::act_ctrl_t tanh_in_ctrl;
	lcu_pkg::act_ctrl_t tanh_c_ctrl;

	logic signed [DW-1:0]    cp_s1, cp_s2, cp_s3;
	logic                    cont_s1, cont_s2, cont_s3;
	logic signed [PFC_W-1:0] pfc_s4;
	logic signed [PIG_W-1:0] pig_s4;
	logic signed [GW-1:0]    go_s4, go_s5, go_s6, go_s7, go_s8;
	logic signed [DW-1:0]    c_s5, c_s6, c_s7, c_s8, c_s9, c_s10;
	logic signed [HP_W-1:0]  hp_s9;
	logic signed [lcu_pkg::HID_W-1:0] h_s10;

	logic signed [GW-1:0]    gf_eff;
	logic signed [SUM_W-1:0] csum;
	logic signed [SUM_W-1:0] crnd;
	logic signed [DW-1:0]    csat;
	logic signed [HP_W-1:0]  hrnd;

	assign in_gate_pre     = s_axis_tdata[0*DW +: DW];
	assign forget_gate_pre = s_axis_tdata[1*DW +: DW];
	assign out_gate_pre    = s_axis_tdata[2*DW +: DW];
	assign cand_pre        = s_axis_tdata[3*DW +: DW];
	assign cell_prev       = s_axis_tdata[4*DW +: DW];

	// advance a stage when it is empty or the next one advances
	always_comb begin
		en[ND+1] = m_axis_tready;
		for (int k = ND; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign vld_d         = {vld_q[ND-1:1], s_axis_tvalid};
	assign s_axis_tready = en[1];
	assign m_axis_tvalid = vld_q[ND];
	assign m_axis_tdata  = {PAD_W'(0), h_s10, c_s10};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= ND; k++) begin
				if (en[k]) vld_q[k] <= vld_d[k];
			end
		end
	end

	assign sig_ctrl     = '{tanh_mode: 1'b0, en: en[3:1]};
	assign tanh_in_ctrl = '{tanh_mode: 1'b1, en: en[3:1]};
	assign tanh_c_ctrl  = '{tanh_mode: 1'b1, en: en[8:6]};

	lcu_act u_act_i (.clk(clk), .ctrl(sig_ctrl),     .x(in_gate_pre),     .y(gi));
	lcu_act u_act_f (.clk(clk), .ctrl(sig_ctrl),     .x(forget_gate_pre), .y(gf));
	lcu_act u_act_o (.clk(clk), .ctrl(sig_ctrl),     .x(out_gate_pre),    .y(go));
	lcu_act u_act_g (.clk(clk), .ctrl(tanh_in_ctrl), .x(cand_pre),        .y(gg));
	lcu_act u_act_c (.clk(clk), .ctrl(tanh_c_ctrl),  .x(c_s5),            .y(tc));

	always_comb begin
		gf_eff = cont_s3 ? gf : GW'(0);
		csum   = SUM_W'(pfc_s4) + SUM_W'(pig_s4) + HALF_S;
		crnd   = csum >>> FB;
		if (crnd > C_MAX)      csat = DW'(C_MAX);
		else if (crnd < C_MIN) csat = DW'(C_MIN);
		else                   csat = DW'(crnd);
		hrnd   = (hp_s9 + HALF_H) >>> FB;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			cp_s1   <= cell_prev;
			cont_s1 <= s_axis_tuser;
		end
		if (en[2]) begin
			cp_s2   <= cp_s1;
			cont_s2 <= cont_s1;
		end
		if (en[3]) begin
			cp_s3   <= cp_s2;
			cont_s3 <= cont_s2;
		end
		if (en[4]) begin
			pfc_s4 <= PFC_W'(gf_eff) * PFC_W'(cp_s3);
			pig_s4 <= PIG_W'(gi) * PIG_W'(gg);
			go_s4  <= go;
		end
		if (en[5]) begin
			c_s5  <= csat;
			go_s5 <= go_s4;
		end
		if (en[6]) begin
			c_s6  <= c_s5;
			go_s6 <= go_s5;
		end
		if (en[7]) begin
			c_s7  <= c_s6;
			go_s7 <= go_s6;
		end
		if (en[8]) begin
			c_s8  <= c_s7;
			go_s8 <= go_s7;
		end
		if (en[9]) begin
			hp_s9 <= HP_W'(go_s8) * HP_W'(tc);
			c_s9  <= c_s8;
		end
		if (en[10]) begin
			h_s10 <= lcu_pkg::HID_W'(hrnd);
			c_s10 <= c_s9;
		end
	end

endmodule

### hdl/lcu_checker.sv
`timescale 1ns / 1ps
module lcu_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [lcu_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	localparam int HW = lcu_pkg::HID_W;
	localparam int DW = lcu_pkg::DATA_WIDTH;
	localparam logic signed [HW-1:0] HID_LIM = HW'(1 << lcu_pkg::FRAC_BITS);

	logic signed [HW-1:0] hid;
	assign hid = m_axis_tdata[DW +: HW];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_hid_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (hid <= HID_LIM) && (hid >= -HID_LIM))
		else $error("hidden output out of range");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[lcu_pkg::OUT_TDATA_W-1:DW+HW] == '0)
		else $error("pad bits set");

	a_full_only: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input blocked without output stall");

	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_axis_tvalid && s_axis_tready)
		else $error("pipeline not empty after reset");

endmodule

bind lstm_cell_update_top lcu_checker u_lcu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

### tb/sv/tb_lstm_cell_update_top.sv
`timescale 1ns / 1ps
module tb_lstm_cell_update_top;

	typedef struct packed {
		logic signed [lcu_pkg::DATA_WIDTH-1:0] ig;
		logic signed [lcu_pkg::DATA_WIDTH-1:0] fg;
		logic signed [lcu_pkg::DATA_WIDTH-1:0] og;
		logic signed [lcu_pkg::DATA_WIDTH-1:0] cg;
		logic signed [lcu_pkg::DATA_WIDTH-1:0] cp;
		logic                                  cont;
	} elem_in_t;

	typedef struct packed {
		logic signed [lcu_pkg::DATA_WIDTH-1:0] cell_val;
		logic signed [lcu_pkg::HID_W-1:0]      hid_val;
	} elem_out_t;

	typedef struct packed {
		logic      has_exp;
		elem_in_t  x;
		elem_out_t y;
	} elem_row_t;

	localparam int N_DIRECTED = 16;
	localparam int N_RANDOM   = 1700;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            s_axis_tvalid;
	logic                            s_axis_tready;
	logic [lcu_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
	logic                            s_axis_tuser;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready;
	logic [lcu_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

	longint    sig_lut [0:lcu_pkg::ACT_TABLE_ENTRIES];
	elem_out_t pending_results [$];
	int        mismatch_count = 0;
	bit        calm = 1'b0;
	elem_row_t directed_rows [0:N_DIRECTED-1];

	lstm_cell_update_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint sig_entry(input int k);
		longint unsigned a;
		longint unsigned term;
		longint unsigned e;
		longint unsigned den;
		longint          sum;
		a    = (longint'(k) << 29) / lcu_pkg::ACT_TABLE_ENTRIES;
		sum  = 64'sd1 << 30;
		term = 64'd1 << 30;
		for (int j = 1; j <= 12; j++) begin
			term = (term * a) / (longint'(j) << 30);
			if (j % 2 == 1) sum = sum - longint'(term);
			else sum = sum + longint'(term);
		end
		e = (sum > 0) ? longint'(sum) : 64'd0;
		for (int j = 0; j <= lcu_pkg::SPAN; j++)
			e = (e * e + (64'd1 << 29)) >> 30;
		den = (64'd1 << 30) + e;
		return longint'(((64'd1 << (lcu_pkg::FRAC_BITS + 30)) + (den >> 1)) / den);
	endfunction

	function automatic longint lut_interp(input longint u);
		longint p;
		longint idx;
		longint fr;
		longint e0;
		longint e1;
		p   = u * lcu_pkg::ACT_TABLE_ENTRIES;
		idx = p >>> lcu_pkg::DATA_WIDTH;
		fr  = p & ((64'sd1 << lcu_pkg::DATA_WIDTH) - 1);
		if (idx >= lcu_pkg::ACT_TABLE_ENTRIES) return sig_lut[lcu_pkg::ACT_TABLE_ENTRIES];
		e0 = sig_lut[idx];
		e1 = sig_lut[idx + 1];
		return e0 + (((e1 - e0) * fr) >>> lcu_pkg::DATA_WIDTH);
	endfunction

	function automatic longint sigmoid_q(input longint x);
		if (x < 0) return (64'sd1 << lcu_pkg::FRAC_BITS) - lut_interp(-x);
		return lut_interp(x);
	endfunction

	function automatic longint tanh_q(input longint x);
		if (x < 0) return (64'sd1 << lcu_pkg::FRAC_BITS) - 2 * lut_interp(-x * 2);
		return 2 * lut_interp(x * 2) - (64'sd1 << lcu_pkg::FRAC_BITS);
	endfunction

	function automatic longint round_frac(input longint v);
		return (v + (64'sd1 << (lcu_pkg::FRAC_BITS - 1))) >>> lcu_pkg::FRAC_BITS;
	endfunction

	function automatic elem_out_t cell_update_predict(input elem_in_t x);
		longint    gi;
		longint    gf;
		longint    go;
		longint    gg;
		longint    c;
		longint    h;
		longint    hi;
		longint    lo;
		elem_out_t r;
		hi = (64'sd1 <<< (lcu_pkg::DATA_WIDTH - 1)) - 1;
		lo = -(64'sd1 <<< (lcu_pkg::DATA_WIDTH - 1));
		gi = sigmoid_q(longint'(x.ig));
		gf = x.cont ? sigmoid_q(longint'(x.fg)) : 0;
		go = sigmoid_q(longint'(x.og));
		gg = tanh_q(longint'(x.cg));
		c  = round_frac(gf * longint'(x.cp) + gi * gg);
		if (c > hi) c = hi;
		if (c < lo) c = lo;
		h = round_frac(go * tanh_q(c));
		r.cell_val = c[lcu_pkg::DATA_WIDTH-1:0];
		r.hid_val  = h[lcu_pkg::HID_W-1:0];
		return r;
	endfunction

	function automatic int gap_len();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [lcu_pkg::DATA_WIDTH-1:0] rand_operand();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0, 1, 2, 3, 4: return lcu_pkg::DATA_WIDTH'($urandom);
			5, 6, 7:       return lcu_pkg::DATA_WIDTH'(int'($urandom_range(0, 16383)) - 8192);
			8: begin
				case ($urandom_range(0, 4))
					0:       return 16'sh7fff;
					1:       return 16'sh8000;
					2:       return 16'sd1;
					3:       return -16'sd1;
					default: return 16'sd0;
				endcase
			end
			default: return lcu_pkg::DATA_WIDTH'((int'($urandom_range(0, 15)) - 8) * 4096);
		endcase
	endfunction

	task automatic send_elem(input elem_in_t x, input int gap);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= lcu_pkg::IN_TDATA_W'({x.cp, x.cg, x.og, x.fg, x.ig});
		s_axis_tuser  <= x.cont;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	always @(posedge clk) begin : result_check
		elem_out_t want;
		logic signed [lcu_pkg::DATA_WIDTH-1:0] got_cell;
		logic signed [lcu_pkg::HID_W-1:0]      got_hid;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_cell = m_axis_tdata[lcu_pkg::DATA_WIDTH-1:0];
			got_hid  = m_axis_tdata[lcu_pkg::DATA_WIDTH +: lcu_pkg::HID_W];
			if (pending_results.size() == 0) begin
				mismatch_count++;
				$error("unexpected result: cell_next %0d, hidden_out %0d", got_cell, got_hid);
			end else begin
				want = pending_results.pop_front();
				if (got_cell !== want.cell_val) begin
					mismatch_count++;
					$error("cell_next: expected %0d, got %0d", want.cell_val, got_cell);
				end
				if (got_hid !== want.hid_val) begin
					mismatch_count++;
					$error("hidden_out: expected %0d, got %0d", want.hid_val, got_hid);
				end
			end
		end
	end

	initial begin
		int stall;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = gap_len();
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	initial begin
		#12_000_000;
		$display("[lstm_cell_update_top] ERROR");
		$finish;
	end

	initial begin
		elem_in_t x;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= 1'b0;
		for (int k = 0; k <= lcu_pkg::ACT_TABLE_ENTRIES; k++)
			sig_lut[k] = sig_entry(k);

		// has_exp, {ig, fg, og, cg, cp, cont}, {cell_next, hidden_out}
		directed_rows = '{
			'{1'b1, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0}, '{16'sd0, 14'sd0}},
			'{1'b1, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1}, '{16'sd0, 14'sd0}},
			'{1'b1, '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sd0, 16'sh7fff, 1'b0},
				'{16'sd0, 14'sd0}},
			'{1'b1, '{16'sh8000, 16'sh8000, 16'sh8000, 16'sd0, 16'sh8000, 1'b0},
				'{16'sd0, 14'sd0}},
			'{1'b0, '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1}, '0},
			'{1'b0, '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1}, '0},
			'{1'b0, '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0}, '0},
			'{1'b0, '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1}, '0},
			'{1'b0, '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 1'b1}, '0},
			'{1'b0, '{16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 1'b1}, '0},
			'{1'b0, '{-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, 1'b1}, '0},
			'{1'b0, '{16'sd4096, -16'sd4096, 16'sd8192, 16'sd2048, 16'sd12288, 1'b1}, '0},
			'{1'b0, '{16'sd4096, 16'sh7fff, 16'sd4096, 16'sd6000, 16'sh7fff, 1'b0}, '0},
			'{1'b0, '{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 1'b1}, '0},
			'{1'b0, '{16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 1'b0}, '0},
			'{1'b0, '{16'sd100, 16'sd30000, 16'sd20000, -16'sd12345, -16'sd20000, 1'b1}, '0}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int n = 0; n < N_DIRECTED; n++) begin
			send_elem(directed_rows[n].x, gap_len());
			if (directed_rows[n].has_exp) pending_results.push_back(directed_rows[n].y);
			else pending_results.push_back(cell_update_predict(directed_rows[n].x));
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			calm   = ((n / 150) % 4 == 1);
			x.ig   = rand_operand();
			x.fg   = rand_operand();
			x.og   = rand_operand();
			x.cg   = rand_operand();
			x.cp   = rand_operand();
			x.cont = ($urandom_range(0, 3) != 0);
			send_elem(x, gap_len());
			pending_results.push_back(cell_update_predict(x));
		end
		calm = 1'b0;
		s_axis_tvalid <= 1'b0;

		while (pending_results.size() > 0) @(posedge clk);
		repeat (lcu_pkg::PIPE_DEPTH + 10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("[lstm_cell_update_top] OK");
		end else begin
			$display("[lstm_cell_update_top] ERROR");
		end
		$finish;
	end

endmodule

### sim.f
hdl/lcu_pkg.sv
hdl/lcu_act.sv
hdl/lstm_cell_update_top.sv
hdl/lcu_checker.sv
tb/sv/tb_lstm_cell_update_top.sv
